// File: sv/fit_pkg.sv
// Shared types and constants for the frame interval timer.
// Used by fit_div, fit_ctrl, fit_dp and frame_interval_timer; depends on nothing.

package fit_pkg;

    localparam int SAMPLES  = 64;
    localparam int HEAD_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int SUM_W    = 32 + HEAD_W;
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int STAMP_W  = 63;
    localparam int ACC_W    = 40;

    localparam logic [31:0] HZ_RESET = 32'd10000000;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_STOP  = 2'd1,
        K_START = 2'd2,
        K_RESET = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STAMP_W-1:0]   stamp;
    } t_in_item;

    typedef struct packed {
        logic [31:0]          avg_frame_ticks;
        logic [15:0]          frame_rate;
        logic signed [63:0]   total_ticks;
        logic                 is_stopped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVT,
        S_DIFF,
        S_GATE,
        S_WSUB,
        S_WADD,
        S_DIVGO,
        S_DIV,
        S_TOT,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath, at most one step per cycle.
    typedef struct packed {
        logic load;
        logic evt;
        logic diff;
        logic gate;
        logic wsub;
        logic wadd;
        logic divgo;
        logic total;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic stopped;
        logic cnt_zero;
        logic div_done;
    } t_stat;

endpackage

// File: sv/frame_interval_timer.sv
// Top level of the frame interval timer: joins the controller and the datapath.
// Depends on fit_pkg, fit_ctrl and fit_dp.
//
// Usage:
// Each input item carries an event kind (frame tick, stop, start, reset) and the
// free-running counter stamp read at that event. Every item yields exactly one
// result item: the mean frame interval of the sample window, the frame count of
// the last completed one-second span, total running time and the stopped flag.
// The input channel takes one item at a time; stall stays high from acceptance
// until the result is loaded into the output register.
// Stop, start, reset and ticks while stopped pass the event, total and output
// states; a running tick also passes the diff, gate, window-subtract, window-add
// and divider-start states and, with samples in the window, the bit-serial
// divider that forms the window mean, one quotient bit per cycle over the sum.
// The next item is accepted the cycle after the result is registered, so the
// result may still wait on a stalled receiver while the next item is at work.
// A stalled receiver holds the result; a finished item waits for the register.
// Reset clears all timing state and sets the counter rate to 10000000 ticks per
// second; the counter rate register is written whenever i_cfg_we is high.

module frame_interval_timer
    import fit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    t_cmd  w_cmd;
    t_stat w_stat;

    fit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fit_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_item  (o_out_item)
    );

endmodule

// File: sv/fit_div.sv
// Bit-serial restoring divider: window sum over sample count, one quotient bit per cycle.
// Depends on fit_pkg.

module fit_div
    import fit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [31:0]       o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[SUM_W-2:0], w_fit};
            if (w_fit) begin
                r_rem <= CNT_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
        end
    end

    // The mean never exceeds the largest sample, so the low 32 bits hold it.
    assign o_done     = r_done;
    assign o_quotient = r_q[31:0];

endmodule

// File: sv/fit_ctrl.sv
// Controller state machine: sequences one item through the datapath and owns the handshakes.
// Depends on fit_pkg.

module fit_ctrl
    import fit_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVT;
            end
            S_EVT: begin
                if (i_stat.is_tick && !i_stat.stopped) n_state = S_DIFF;
                else n_state = S_TOT;
            end
            S_DIFF:  n_state = S_GATE;
            S_GATE:  n_state = S_WSUB;
            S_WSUB:  n_state = S_WADD;
            S_WADD:  n_state = S_DIVGO;
            S_DIVGO: begin
                if (i_stat.cnt_zero) n_state = S_TOT;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_TOT;
            end
            S_TOT:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.evt      = (r_state == S_EVT);
        o_cmd.diff     = (r_state == S_DIFF);
        o_cmd.gate     = (r_state == S_GATE);
        o_cmd.wsub     = (r_state == S_WSUB);
        o_cmd.wadd     = (r_state == S_WADD);
        o_cmd.divgo    = (r_state == S_DIVGO);
        o_cmd.total    = (r_state == S_TOT);
        o_cmd.out_load = (r_state == S_OUT) && w_out_free;

        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/fit_dp.sv
// Datapath: time stamps, sample window memory, per-second counters and result register.
// Depends on fit_pkg and fit_div.

module fit_dp
    import fit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  t_in_item    i_in_item,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_out_item   o_out_item
);

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SAMPLES);
    localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(SAMPLES - 1);

    logic [31:0]        r_hz;
    t_kind              r_kind;
    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] r_last;
    logic [STAMP_W-1:0] r_cur;
    logic [STAMP_W-1:0] r_base;
    logic [STAMP_W-1:0] r_stop;
    logic [63:0]        r_paused;
    logic               r_stopped;

    logic [31:0]        r_ring [SAMPLES];
    logic [31:0]        r_ring_rd;
    logic [HEAD_W-1:0]  r_head;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [31:0]        r_avg;
    logic [15:0]        r_frames;
    logic [ACC_W-1:0]   r_accum;
    logic [15:0]        r_shown;

    logic [31:0]        r_delta;
    logic [31:0]        r_absdiff;
    logic               r_in_win;
    logic [63:0]        r_tmp;
    t_out_item          r_out;

    logic [63:0]        w_raw;
    logic [31:0]        w_delta;
    logic               w_full;
    logic               w_div_start;
    logic               w_div_done;
    logic [31:0]        w_quot;

    // A stamp below the previous one yields a borrow and measures zero.
    assign w_raw  = {1'b0, r_stamp} - {1'b0, r_last};
    assign w_full = (r_count == CNT_FULL);

    always_comb begin
        if (w_raw[63]) w_delta = '0;
        else if (|w_raw[62:32]) w_delta = '1;
        else w_delta = w_raw[31:0];
    end

    assign w_div_start = i_cmd.divgo && (r_count != '0);

    fit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.wadd && r_in_win) r_ring[r_head] <= r_delta;
        r_ring_rd <= r_ring[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz      <= HZ_RESET;
            r_last    <= '0;
            r_cur     <= '0;
            r_base    <= '0;
            r_stop    <= '0;
            r_paused  <= '0;
            r_stopped <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_avg     <= '0;
            r_frames  <= '0;
            r_accum   <= '0;
            r_shown   <= '0;
        end else begin
            if (i_cfg_we) r_hz <= i_cfg_wdata;

            if (i_cmd.evt) begin
                case (r_kind)
                    K_TICK: begin
                        if (r_stopped) begin
                            r_avg <= '0;
                        end else begin
                            r_cur <= r_stamp;
                            r_last <= r_stamp;
                        end
                    end
                    K_STOP: begin
                        if (!r_stopped) begin
                            r_stop    <= r_stamp;
                            r_stopped <= 1'b1;
                        end
                    end
                    K_START: begin
                        if (r_stopped) begin
                            r_paused  <= r_paused + {1'b0, r_stamp} - {1'b0, r_stop};
                            r_last    <= r_stamp;
                            r_stop    <= '0;
                            r_stopped <= 1'b0;
                        end
                    end
                    default: begin
                        r_base    <= r_stamp;
                        r_last    <= r_stamp;
                        r_stop    <= '0;
                        r_stopped <= 1'b0;
                    end
                endcase
            end

            if (i_cmd.diff) begin
                r_accum <= r_accum + ACC_W'(r_delta);
                if (r_frames != 16'hFFFF) r_frames <= r_frames + 1'b1;
            end

            if (i_cmd.gate && (r_accum > ACC_W'(r_hz))) begin
                r_shown  <= r_frames;
                r_frames <= '0;
                r_accum  <= '0;
            end

            // The oldest sample drops out before the new one is added.
            if (i_cmd.wsub && r_in_win && w_full) begin
                r_sum <= r_sum - SUM_W'(r_ring_rd);
            end

            if (i_cmd.wadd && r_in_win) begin
                r_sum <= r_sum + SUM_W'(r_delta);
                if (!w_full) r_count <= r_count + 1'b1;
                if (r_head == HEAD_MAX) r_head <= '0;
                else r_head <= r_head + 1'b1;
            end

            if (i_cmd.divgo && (r_count == '0)) r_avg <= '0;
            if (w_div_done) r_avg <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_item.kind;
            r_stamp <= i_in_item.stamp;
        end
        if (i_cmd.evt) r_delta <= w_delta;
        if (i_cmd.diff) begin
            if (r_delta >= r_avg) r_absdiff <= r_delta - r_avg;
            else r_absdiff <= r_avg - r_delta;
        end
        if (i_cmd.gate) r_in_win <= (r_absdiff < r_hz);
        if (i_cmd.total) begin
            if (r_stopped) r_tmp <= {1'b0, r_stop} - r_paused;
            else r_tmp <= {1'b0, r_cur} - r_paused;
        end
        if (i_cmd.out_load) begin
            r_out.avg_frame_ticks <= r_avg;
            r_out.frame_rate      <= r_shown;
            r_out.total_ticks     <= $signed(r_tmp - {1'b0, r_base});
            r_out.is_stopped      <= r_stopped;
        end
    end

    assign o_stat.is_tick  = (r_kind == K_TICK);
    assign o_stat.stopped  = r_stopped;
    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.div_done = w_div_done;
    assign o_out_item      = r_out;

endmodule
